### src/ecpa_pkg.sv
`default_nettype none
package ecpa_pkg;

   localparam int FIELD_BITS  = 64;
   localparam int SCALAR_BITS = 64;
   localparam int SIDX_W      = (SCALAR_BITS > 1) ? $clog2(SCALAR_BITS) : 1;
   localparam int MCNT_W      = $clog2(FIELD_BITS);

   localparam int REQ_BITS   = 5 * FIELD_BITS + 2;
   localparam int REQ_W      = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS   = 2 * FIELD_BITS + 1;
   localparam int RSP_W      = ((RSP_BITS + 7) / 8) * 8;

   localparam int CSR_IDX_W  = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_PRIME = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CURVE_A     = 8'd1;

   localparam logic ACT_ADD = 1'b0;
   localparam logic ACT_MUL = 1'b1;

   typedef logic [FIELD_BITS-1:0] fe_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RED,
      ST_LOAD,
      ST_DEC,
      ST_DBL_SQ,
      ST_DBL_A1,
      ST_DBL_A2,
      ST_DBL_A3,
      ST_INV_START,
      ST_INV_STEP,
      ST_INV_MR,
      ST_INV_SQ,
      ST_S_MUL,
      ST_X_SQ,
      ST_X_SUB1,
      ST_X_SUB2,
      ST_Y_SUB,
      ST_Y_MUL,
      ST_Y_SUB2,
      ST_NEXT,
      ST_OUT
   } state_type;

   // Modular add and subtract for operands already below the modulus.
   function automatic fe_type fadd(input fe_type a, input fe_type b, input fe_type m);
      logic [FIELD_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[FIELD_BITS-1:0];
   endfunction

   function automatic fe_type fsub(input fe_type a, input fe_type b, input fe_type m);
      fe_type r;
      if (a >= b) begin
         r = a - b;
      end else begin
         r = a + (m - b);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### src/ecpa_mul.sv
`default_nettype none
module ecpa_mul
   import ecpa_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   start,
   input  wire fe_type op_a,
   input  wire fe_type op_b,
   input  wire fe_type modulus,
   output logic        done,
   output fe_type      product
);

   logic              busy_ff;
   logic              done_ff;
   logic [MCNT_W-1:0] cnt_ff;
   fe_type            acc_ff;
   fe_type            a_ff;
   fe_type            b_ff;
   fe_type            dbl;
   fe_type            acc_in;

   // One multiplier bit per cycle, most significant first.
   always_comb begin
      dbl = fadd(acc_ff, acc_ff, modulus);
      if (b_ff[FIELD_BITS-1]) begin
         acc_in = fadd(dbl, a_ff, modulus);
      end else begin
         acc_in = dbl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= MCNT_W'(FIELD_BITS - 1);
            acc_ff  <= '0;
            a_ff    <= op_a;
            b_ff    <= op_b;
         end else if (busy_ff) begin
            acc_ff <= acc_in;
            b_ff   <= b_ff << 1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

`ifndef NO_ASSERTIONS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("multiplier started while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("multiplier done without a run");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("multiplier done held longer than a cycle");
`endif

endmodule
`default_nettype wire

### src/ec_point_add_and_scalar_mult_top.sv
`default_nettype none
// Elliptic-curve point unit over a prime field, y^2 = x^3 + a x + b.
// The req_ stream carries one word per operation: tuser selects add of the two
// points or multiply of the first point by the scalar. The rsp_ stream returns
// one word per operation with the result point and its infinity flag.
// The csr_ channel writes the field prime (index 0) and curve a (index 1); it
// is always ready. The user writes it only while the unit is idle; the block
// itself does not enforce this. Work is done by one bit-serial modular
// multiplier. Five reductions open each operation. One point addition takes
// up to 2 * FIELD_BITS + 4 products, most for the inversion by exponentiation;
// a scalar multiply takes up to 2 * SCALAR_BITS point operations.
// One operation is in flight at a time; a new word is taken when the unit is
// idle, even while an earlier result waits on the rsp_ side. If the receiver
// stalls, the result word is held and the next operation waits at its end.
// Reset (synchronous, active high) returns the unit to idle with prime 223
// and a = 0, and drops any pending result.
module ec_point_add_and_scalar_mult_top
   import ecpa_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // first_x, first_y, first_infinity, second_x, second_y, second_infinity, scalar
   input  wire logic [REQ_W-1:0]     req_tdata,
   // action
   input  wire logic                 req_tuser,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // result_x, result_y, result_infinity
   output logic [RSP_W-1:0]          rsp_tdata,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0]          csr_data
);

   state_type state_ff, state_in;

   fe_type prime_ff, curve_a_ff, m;

   logic                   action_ff;
   logic [SCALAR_BITS-1:0] k_ff;
   logic [SIDX_W-1:0]      bit_ff;
   logic                   dbl_phase_ff;
   logic [2:0]             red_idx_ff;
   logic                   pend_ff;

   fe_type px_ff, py_ff, bx_ff, by_ff, ax_ff, ay_ff, rx_ff, ry_ff, ca_ff;
   logic   pinf_ff, ainf_ff, binf_ff, rinf_ff;
   fe_type num_ff, base_ff, invr_ff, e_ff, t_ff, s_ff;

   logic   rsp_valid_ff;
   fe_type out_x_ff, out_y_ff;
   logic   out_inf_ff;

   logic   is_mul_state;
   logic   mul_start;
   fe_type mul_a, mul_b, red_src;
   logic   mul_done;
   fe_type mul_p;
   logic   req_fire, out_go;

   assign m = (prime_ff < fe_type'(2)) ? fe_type'(1) : prime_ff;

   ecpa_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (m),
      .done    (mul_done),
      .product (mul_p)
   );

   assign req_fire = req_tvalid && req_tready;
   assign out_go   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      unique case (red_idx_ff)
         3'd0:    red_src = px_ff;
         3'd1:    red_src = py_ff;
         3'd2:    red_src = bx_ff;
         3'd3:    red_src = by_ff;
         default: red_src = curve_a_ff;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_fire) state_in = ST_RED;
         ST_RED:       if (mul_done && red_idx_ff == 3'd4) state_in = ST_LOAD;
         ST_LOAD:      state_in = ST_DEC;
         ST_DEC: begin
            priority if (ainf_ff || binf_ff) state_in = ST_NEXT;
            else if (ax_ff == bx_ff && ay_ff != by_ff) state_in = ST_NEXT;
            else if (ax_ff != bx_ff) state_in = ST_INV_START;
            else if (ay_ff == '0) state_in = ST_NEXT;
            else state_in = ST_DBL_SQ;
         end
         ST_DBL_SQ:    if (mul_done) state_in = ST_DBL_A1;
         ST_DBL_A1:    state_in = ST_DBL_A2;
         ST_DBL_A2:    state_in = ST_DBL_A3;
         ST_DBL_A3:    state_in = ST_INV_START;
         ST_INV_START: begin
            if (base_ff == '0 || m < fe_type'(2)) state_in = ST_S_MUL;
            else state_in = ST_INV_STEP;
         end
         ST_INV_STEP: begin
            priority if (e_ff == '0) state_in = ST_S_MUL;
            else if (e_ff[0]) state_in = ST_INV_MR;
            else state_in = ST_INV_SQ;
         end
         ST_INV_MR:    if (mul_done) state_in = ST_INV_SQ;
         ST_INV_SQ:    if (mul_done) state_in = ST_INV_STEP;
         ST_S_MUL:     if (mul_done) state_in = ST_X_SQ;
         ST_X_SQ:      if (mul_done) state_in = ST_X_SUB1;
         ST_X_SUB1:    state_in = ST_X_SUB2;
         ST_X_SUB2:    state_in = ST_Y_SUB;
         ST_Y_SUB:     state_in = ST_Y_MUL;
         ST_Y_MUL:     if (mul_done) state_in = ST_Y_SUB2;
         ST_Y_SUB2:    state_in = ST_NEXT;
         ST_NEXT: begin
            priority if (action_ff == ACT_ADD) state_in = ST_OUT;
            else if (dbl_phase_ff && k_ff[bit_ff]) state_in = ST_DEC;
            else if (bit_ff == '0) state_in = ST_OUT;
            else state_in = ST_DEC;
         end
         ST_OUT:       if (out_go) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Control outputs and multiplier operands.
   always_comb begin
      is_mul_state = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      unique case (state_ff)
         ST_RED:    begin is_mul_state = 1'b1; mul_a = fe_type'(1); mul_b = red_src; end
         ST_DBL_SQ: begin is_mul_state = 1'b1; mul_a = ax_ff;   mul_b = ax_ff;   end
         ST_INV_MR: begin is_mul_state = 1'b1; mul_a = invr_ff; mul_b = base_ff; end
         ST_INV_SQ: begin is_mul_state = 1'b1; mul_a = base_ff; mul_b = base_ff; end
         ST_S_MUL:  begin is_mul_state = 1'b1; mul_a = num_ff;  mul_b = invr_ff; end
         ST_X_SQ:   begin is_mul_state = 1'b1; mul_a = s_ff;    mul_b = s_ff;    end
         ST_Y_MUL:  begin is_mul_state = 1'b1; mul_a = s_ff;    mul_b = num_ff;  end
         default:   is_mul_state = 1'b0;
      endcase
      mul_start  = is_mul_state && !pend_ff;
      req_tready = (state_ff == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prime_ff     <= fe_type'(223);
         curve_a_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (mul_start) begin
            pend_ff <= 1'b1;
         end else if (mul_done) begin
            pend_ff <= 1'b0;
         end
         if (csr_valid) begin
            if (csr_index == CSR_FIELD_PRIME) prime_ff <= csr_data[FIELD_BITS-1:0];
            if (csr_index == CSR_CURVE_A) curve_a_ff <= csr_data[FIELD_BITS-1:0];
         end
         if (state_ff == ST_OUT && out_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               action_ff  <= req_tuser;
               px_ff      <= req_tdata[FIELD_BITS-1:0];
               py_ff      <= req_tdata[2*FIELD_BITS-1:FIELD_BITS];
               pinf_ff    <= req_tdata[2*FIELD_BITS];
               bx_ff      <= req_tdata[3*FIELD_BITS:2*FIELD_BITS+1];
               by_ff      <= req_tdata[4*FIELD_BITS:3*FIELD_BITS+1];
               binf_ff    <= req_tdata[4*FIELD_BITS+1];
               k_ff       <= req_tdata[4*FIELD_BITS+1+SCALAR_BITS:4*FIELD_BITS+2];
               red_idx_ff <= 3'd0;
            end
         end
         ST_RED: begin
            if (mul_done) begin
               unique case (red_idx_ff)
                  3'd0:    px_ff <= mul_p;
                  3'd1:    py_ff <= mul_p;
                  3'd2:    bx_ff <= mul_p;
                  3'd3:    by_ff <= mul_p;
                  default: ca_ff <= mul_p;
               endcase
               red_idx_ff <= red_idx_ff + 3'd1;
            end
         end
         ST_LOAD: begin
            if (action_ff == ACT_ADD) begin
               ax_ff   <= px_ff;
               ay_ff   <= py_ff;
               ainf_ff <= pinf_ff;
            end else begin
               rinf_ff      <= 1'b1;
               rx_ff        <= '0;
               ry_ff        <= '0;
               ainf_ff      <= 1'b1;
               binf_ff      <= 1'b1;
               bit_ff       <= SIDX_W'(SCALAR_BITS - 1);
               dbl_phase_ff <= 1'b1;
            end
         end
         ST_DEC: begin
            priority if (ainf_ff) begin
               rx_ff <= bx_ff; ry_ff <= by_ff; rinf_ff <= binf_ff;
            end else if (binf_ff) begin
               rx_ff <= ax_ff; ry_ff <= ay_ff; rinf_ff <= 1'b0;
            end else if (ax_ff == bx_ff && ay_ff != by_ff) begin
               rinf_ff <= 1'b1;
            end else if (ax_ff != bx_ff) begin
               num_ff  <= fsub(by_ff, ay_ff, m);
               base_ff <= fsub(bx_ff, ax_ff, m);
            end else if (ay_ff == '0) begin
               rinf_ff <= 1'b1;
            end else begin
               rinf_ff <= 1'b0;
            end
         end
         ST_DBL_SQ:  if (mul_done) t_ff <= mul_p;
         ST_DBL_A1:  num_ff <= fadd(t_ff, t_ff, m);
         ST_DBL_A2:  num_ff <= fadd(num_ff, t_ff, m);
         ST_DBL_A3: begin
            num_ff  <= fadd(num_ff, ca_ff, m);
            base_ff <= fadd(ay_ff, ay_ff, m);
         end
         ST_INV_START: begin
            if (base_ff == '0 || m < fe_type'(2)) begin
               invr_ff <= '0;
            end else begin
               invr_ff <= fe_type'(1);
               e_ff    <= m - fe_type'(2);
            end
         end
         ST_INV_STEP: invr_ff <= invr_ff;
         ST_INV_MR:  if (mul_done) invr_ff <= mul_p;
         ST_INV_SQ: begin
            if (mul_done) begin
               base_ff <= mul_p;
               e_ff    <= e_ff >> 1;
            end
         end
         ST_S_MUL:   if (mul_done) s_ff <= mul_p;
         ST_X_SQ:    if (mul_done) t_ff <= mul_p;
         ST_X_SUB1:  t_ff <= fsub(t_ff, ax_ff, m);
         ST_X_SUB2:  t_ff <= fsub(t_ff, bx_ff, m);
         ST_Y_SUB:   num_ff <= fsub(ax_ff, t_ff, m);
         ST_Y_MUL:   if (mul_done) num_ff <= mul_p;
         ST_Y_SUB2: begin
            rx_ff   <= t_ff;
            ry_ff   <= fsub(num_ff, ay_ff, m);
            rinf_ff <= 1'b0;
         end
         ST_NEXT: begin
            // Next point operation of the double-and-add walk.
            ax_ff   <= rx_ff;
            ay_ff   <= ry_ff;
            ainf_ff <= rinf_ff;
            if (dbl_phase_ff && k_ff[bit_ff]) begin
               bx_ff        <= px_ff;
               by_ff        <= py_ff;
               binf_ff      <= pinf_ff;
               dbl_phase_ff <= 1'b0;
            end else begin
               bx_ff        <= rx_ff;
               by_ff        <= ry_ff;
               binf_ff      <= rinf_ff;
               dbl_phase_ff <= 1'b1;
               if (bit_ff != '0) bit_ff <= bit_ff - 1'b1;
            end
         end
         ST_OUT: begin
            if (out_go) begin
               out_x_ff   <= rinf_ff ? fe_type'(0) : rx_ff;
               out_y_ff   <= rinf_ff ? fe_type'(0) : ry_ff;
               out_inf_ff <= rinf_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W - RSP_BITS){1'b0}}, out_inf_ff, out_y_ff, out_x_ff};

`ifndef NO_ASSERTIONS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_RED)
      else $error("accepted word did not start reduction");
   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> pend_ff)
      else $error("product arrived with no request pending");
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output state");
   a_inf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_inf_ff |-> out_x_ff == '0 && out_y_ff == '0)
      else $error("infinity result with nonzero coordinates");
`endif

endmodule
`default_nettype wire

### bench/tb_top.sv
module tb_top;
   import ecpa_pkg::*;

   typedef struct {
      logic   action;
      fe_type ax, ay;
      logic   ainf;
      fe_type bx, by;
      logic   binf;
      logic [63:0] k;
   } op_t;

   typedef struct {
      fe_type x, y;
      logic   inf;
   } point_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   ec_point_add_and_scalar_mult_top uut (.*);

   always #5 clock = ~clock;

   op_t    pending_ops[$];
   point_t expected_pts[$];
   fe_type prime_reg = 64'd223;
   fe_type a_reg = '0;
   int     idle_mode = 0;
   logic   req_took = 1'b0;
   int     mismatches = 0;
   int     cycles = 0;
   int     hold_cnt = 0;
   logic   hold_go = 1'b0;
   logic   hold_used = 1'b0;

   function automatic fe_type m_add(fe_type a, fe_type b, fe_type m);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[63:0];
   endfunction

   function automatic fe_type m_sub(fe_type a, fe_type b, fe_type m);
      return (a >= b) ? a - b : a + (m - b);
   endfunction

   function automatic fe_type m_mul(fe_type a, fe_type b, fe_type m);
      logic [127:0] pr;
      pr = {64'b0, a} * {64'b0, b};
      pr = pr % {64'b0, m};
      return pr[63:0];
   endfunction

   // Fermat inverse; zero maps to zero.
   function automatic fe_type m_inv(fe_type a, fe_type m);
      fe_type e, r, base;
      if (a == 0 || m < 2) return '0;
      e = m - 2;
      r = 1;
      base = a;
      while (e != 0) begin
         if (e[0]) r = m_mul(r, base, m);
         base = m_mul(base, base, m);
         e = e >> 1;
      end
      return r % m;
   endfunction

   function automatic point_t pt_sum(point_t p, point_t q, fe_type a, fe_type m);
      point_t r;
      fe_type s, x3, num, den;
      r = '{x: '0, y: '0, inf: 1'b1};
      if (p.inf) return q;
      if (q.inf) return p;
      if (p.x == q.x && p.y != q.y) return r;
      if (p.x != q.x) begin
         s = m_mul(m_sub(q.y, p.y, m), m_inv(m_sub(q.x, p.x, m), m), m);
         x3 = m_sub(m_sub(m_mul(s, s, m), p.x, m), q.x, m);
      end else begin
         if (p.y == 0) return r;
         num = m_mul(p.x, p.x, m);
         num = m_add(m_add(m_add(num, num, m), num, m), a, m);
         den = m_add(p.y, p.y, m);
         s = m_mul(num, m_inv(den, m), m);
         x3 = m_sub(m_mul(s, s, m), m_add(p.x, p.x, m), m);
      end
      r.x = x3;
      r.y = m_sub(m_mul(s, m_sub(p.x, x3, m), m), p.y, m);
      r.inf = 1'b0;
      return r;
   endfunction

   function automatic point_t curve_result(op_t op);
      fe_type m, a;
      point_t p, q, r;
      m = (prime_reg < 2) ? 64'd1 : prime_reg;
      a = a_reg % m;
      if (op.ainf) p = '{x: '0, y: '0, inf: 1'b1};
      else p = '{x: op.ax % m, y: op.ay % m, inf: 1'b0};
      if (op.binf) q = '{x: '0, y: '0, inf: 1'b1};
      else q = '{x: op.bx % m, y: op.by % m, inf: 1'b0};
      if (op.action == ACT_ADD) begin
         r = pt_sum(p, q, a, m);
      end else begin
         r = '{x: '0, y: '0, inf: 1'b1};
         for (int i = SCALAR_BITS - 1; i >= 0; i--) begin
            r = pt_sum(r, r, a, m);
            if (op.k[i]) r = pt_sum(r, p, a, m);
         end
      end
      if (r.inf) begin
         r.x = '0;
         r.y = '0;
      end
      return r;
   endfunction

   function automatic fe_type rand64();
      return {$urandom, $urandom};
   endfunction

   // Mostly reduced operands, some with related second points, some raw noise.
   function automatic op_t random_op(fe_type m, int kbits);
      op_t op;
      int kind;
      op.action = $urandom_range(1);
      op.k = rand64() & ((64'd1 << kbits) - 1);
      if ($urandom_range(99) < 30) begin
         op.ax = rand64();
         op.ay = rand64();
         op.bx = rand64();
         op.by = rand64();
         op.ainf = ($urandom_range(9) == 0);
         op.binf = ($urandom_range(9) == 0);
         op.k = rand64() & ((64'd1 << kbits) - 1);
         return op;
      end
      op.ax = rand64() % m;
      op.ay = rand64() % m;
      op.ainf = ($urandom_range(19) == 0);
      op.binf = 1'b0;
      kind = $urandom_range(4);
      case (kind)
         0: begin
            op.bx = op.ax;
            op.by = op.ay;
         end
         1: begin
            op.bx = op.ax;
            op.by = m_sub(0, op.ay, m);
         end
         2: begin
            op.bx = rand64() % m;
            op.by = rand64() % m;
            op.binf = 1'b1;
         end
         default: begin
            op.bx = rand64() % m;
            op.by = rand64() % m;
         end
      endcase
      return op;
   endfunction

   function automatic op_t make_op(logic act, fe_type ax, fe_type ay, logic ai,
                                   fe_type bx, fe_type by, logic bi, logic [63:0] k);
      op_t op;
      op = '{action: act, ax: ax, ay: ay, ainf: ai, bx: bx, by: by, binf: bi, k: k};
      return op;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      req_took <= req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         expected_pts.push_back(curve_result(make_op(req_tuser, req_tdata[63:0],
            req_tdata[127:64], req_tdata[128], req_tdata[192:129],
            req_tdata[256:193], req_tdata[257], req_tdata[321:258])));
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pts.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected result word %h", rsp_tdata);
         end else begin
            point_t e;
            e = expected_pts.pop_front();
            if (rsp_tdata[63:0] !== e.x || rsp_tdata[127:64] !== e.y
                || rsp_tdata[128] !== e.inf) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: expected x=%h y=%h inf=%b got x=%h y=%h inf=%b",
                           e.x, e.y, e.inf, rsp_tdata[63:0], rsp_tdata[127:64],
                           rsp_tdata[128]);
            end
         end
      end
      if (cycles > 6000000) begin
         $display("** ec_point_add_and_scalar_mult_top: FAILED **");
         $finish;
      end
   end

   // Long receiver hold-off, armed once.
   always @(negedge clock) begin
      if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
      end else if (hold_go && !hold_used) begin
         hold_cnt <= 8000;
         hold_used <= 1'b1;
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_took)) begin
         if (pending_ops.size() != 0 &&
             !((idle_mode == 1 || idle_mode == 3) &&
               $urandom_range(99) < ((idle_mode == 1) ? 70 : 32))) begin
            op_t op;
            op = pending_ops.pop_front();
            req_tdata <= {{(REQ_W - 322){1'b0}},
                          op.k, op.binf, op.by, op.bx, op.ainf, op.ay, op.ax};
            req_tuser <= op.action;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !reset && hold_cnt == 0 &&
                    !((idle_mode == 2 || idle_mode == 3) &&
                      $urandom_range(99) < ((idle_mode == 2) ? 70 : 32));
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_FIELD_PRIME) prime_reg = val;
      else if (idx == CSR_CURVE_A) a_reg = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pending_ops.size() != 0 || req_tvalid || expected_pts.size() != 0);
      repeat (20) @(negedge clock);
   endtask

   task automatic run_phase(fe_type p, fe_type a, int mode, int count, int kbits);
      write_csr(CSR_FIELD_PRIME, p);
      write_csr(CSR_CURVE_A, a);
      idle_mode = mode;
      for (int i = 0; i < count; i++) pending_ops.push_back(random_op(p, kbits));
      drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Reset values: prime 223, a = 0; curve y^2 = x^3 + 7 holds (47,71), (17,56).
      idle_mode = 0;
      pending_ops.push_back(make_op(ACT_ADD, 5, 9, 1, 47, 71, 0, 0));
      pending_ops.push_back(make_op(ACT_ADD, 47, 71, 0, 3, 3, 1, '1));
      pending_ops.push_back(make_op(ACT_ADD, '1, '1, 1, '1, '1, 1, 0));
      pending_ops.push_back(make_op(ACT_ADD, 47, 71, 0, 47, 152, 0, 0));
      pending_ops.push_back(make_op(ACT_ADD, 47, 71, 0, 47, 71, 0, 0));
      pending_ops.push_back(make_op(ACT_ADD, 60, 0, 0, 60, 0, 0, 0));
      pending_ops.push_back(make_op(ACT_ADD, 47, 71, 0, 17, 56, 0, 0));
      pending_ops.push_back(make_op(ACT_ADD, '1, '1, 0, 64'h8000_0000_0000_0000,
                                    64'h1234_5678_9abc_def0, 0, '1));
      pending_ops.push_back(make_op(ACT_MUL, 47, 71, 0, '1, '1, 0, 0));
      pending_ops.push_back(make_op(ACT_MUL, 47, 71, 0, 1, 2, 1, 1));
      pending_ops.push_back(make_op(ACT_MUL, 47, 71, 0, 0, 0, 0, 21));
      pending_ops.push_back(make_op(ACT_MUL, 47, 71, 1, 0, 0, 0, 13));
      pending_ops.push_back(make_op(ACT_MUL, '1, '1, 0, '1, '1, 1, 7));
      pending_ops.push_back(make_op(ACT_MUL, 17, 56, 0, 0, 0, 0, '1));
      drain();
      // Receiver holds off while the sender keeps offering words.
      hold_go = 1'b1;
      run_phase(223, 0, 1, 18, 4);
      run_phase(97, 2, 2, 18, 4);
      run_phase(3, '1, 3, 15, 4);
      run_phase(64'hFFFF_FFFF_FFFF_FFC5, rand64(), 0, 8, 2);
      run_phase(65521, rand64(), 3, 22, 4);
      if (mismatches == 0) begin
         $display("** ec_point_add_and_scalar_mult_top: PASSED **");
      end else begin
         $display("** ec_point_add_and_scalar_mult_top: FAILED **");
      end
      $finish;
   end

endmodule

### files.f
src/ecpa_pkg.sv
src/ecpa_mul.sv
src/ec_point_add_and_scalar_mult_top.sv
bench/tb_top.sv
